// File: rtl/hsr_pkg.sv
// Package for the HDLC segment reassembly control block.
// Holds the descriptor, header and result types, status codes and limits.
// No dependencies; imported by every module under rtl/.
package hsr_pkg;

    // Default ceiling on a reassembled message length
    localparam int unsigned LENGTH_LIMIT_DEF = 65535;

    localparam int unsigned LEN_W  = 16;
    localparam int unsigned ADDR_W = 32;
    localparam int unsigned SIZE_W = 3;
    localparam int unsigned CTL_W  = 8;
    localparam int unsigned KIND_W = 2;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_INCOMPLETE = 2'd1,
        ST_SEG_ERR    = 2'd2,
        ST_OVERFLOW   = 2'd3
    } hsr_status_t;

    // Header fields kept from the first segment
    typedef struct packed {
        logic [ADDR_W-1:0] dest_raw;
        logic [SIZE_W-1:0] dest_size;
        logic [ADDR_W-1:0] src_raw;
        logic [SIZE_W-1:0] src_size;
        logic [CTL_W-1:0]  control;
        logic [KIND_W-1:0] kind;
    } hsr_hdr_t;

    // One received frame descriptor
    typedef struct packed {
        hsr_hdr_t         hdr;
        logic             segmented;
        logic [LEN_W-1:0] info_length;
    } hsr_desc_t;

    // One result word
    typedef struct packed {
        hsr_status_t       status;
        logic              complete;
        logic [LEN_W-1:0]  write_offset;
        logic [LEN_W-1:0]  total_length;
        logic [ADDR_W-1:0] dest_raw;
        logic [SIZE_W-1:0] dest_size;
        logic [ADDR_W-1:0] src_raw;
        logic [SIZE_W-1:0] src_size;
        logic [CTL_W-1:0]  control;
    } hsr_result_t;

endpackage

// File: rtl/hsr_in_stage.sv
// Input register stage of the HDLC segment reassembly control block.
// Captures one descriptor word per cycle while downstream drains it; depends on hsr_pkg.
module hsr_in_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  hsr_pkg::hsr_desc_t s_desc,
    output logic              q_valid,
    input  logic              q_ready,
    output hsr_pkg::hsr_desc_t q_desc
);
    import hsr_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    hsr_desc_t desc_reg;

    // Take a new word whenever the stage is empty or drains this cycle
    assign s_ready = !valid_reg || q_ready;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (q_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Hold the descriptor until the next accepted word
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            desc_reg <= s_desc;
        end
    end

    assign q_valid = valid_reg;
    assign q_desc  = desc_reg;

endmodule

// File: rtl/hsr_track.sv
// Reassembly tracker: pending message state, length limit register and
// the per-descriptor decision. Depends on hsr_pkg.
module hsr_track #(
    parameter int unsigned LENGTH_LIMIT = hsr_pkg::LENGTH_LIMIT_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr,
    input  logic [hsr_pkg::LEN_W-1:0] cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  hsr_pkg::hsr_desc_t        in_desc,
    output logic                      res_valid,
    input  logic                      res_ready,
    output hsr_pkg::hsr_result_t      res
);
    import hsr_pkg::*;

    localparam logic [LEN_W-1:0] LIMIT = LEN_W'(LENGTH_LIMIT);

    logic             pending_reg;
    logic             pending_next;
    logic [LEN_W-1:0] plen_reg;
    logic [LEN_W-1:0] plen_next;
    hsr_hdr_t         held_reg;
    hsr_hdr_t         held_next;
    logic [LEN_W-1:0] max_reg;

    logic             fire;
    logic [LEN_W-1:0] limit;
    logic [LEN_W:0]   sum;
    logic             hdr_match;
    hsr_result_t      r;

    assign fire      = in_valid && res_ready;
    assign in_ready  = res_ready;
    assign res_valid = in_valid;

    // Effective limit: zero or above the ceiling means the ceiling
    assign limit = (max_reg == '0 || max_reg > LIMIT) ? LIMIT : max_reg;

    // Running total without wrap
    assign sum = {1'b0, plen_reg} + {1'b0, in_desc.info_length};

    assign hdr_match = (held_reg.dest_raw  == in_desc.hdr.dest_raw)  &&
                       (held_reg.dest_size == in_desc.hdr.dest_size) &&
                       (held_reg.src_raw   == in_desc.hdr.src_raw)   &&
                       (held_reg.src_size  == in_desc.hdr.src_size)  &&
                       (held_reg.kind      == in_desc.hdr.kind);

    // Decide status, offset and next pending state for this descriptor
    always_comb begin
        r            = '0;
        r.status     = ST_OK;
        pending_next = pending_reg;
        plen_next    = plen_reg;
        held_next    = held_reg;
        if (!pending_reg) begin
            if (in_desc.info_length > limit) begin
                r.status = ST_OVERFLOW;
            end else if (!in_desc.segmented) begin
                r.complete     = 1'b1;
                r.total_length = in_desc.info_length;
                r.dest_raw     = in_desc.hdr.dest_raw;
                r.dest_size    = in_desc.hdr.dest_size;
                r.src_raw      = in_desc.hdr.src_raw;
                r.src_size     = in_desc.hdr.src_size;
                r.control      = in_desc.hdr.control;
            end else begin
                r.status     = ST_INCOMPLETE;
                pending_next = 1'b1;
                plen_next    = in_desc.info_length;
                held_next    = in_desc.hdr;
            end
        end else if (!hdr_match) begin
            r.status     = ST_SEG_ERR;
            pending_next = 1'b0;
        end else if (sum > {1'b0, limit}) begin
            r.status     = ST_OVERFLOW;
            pending_next = 1'b0;
        end else begin
            r.write_offset = plen_reg;
            plen_next      = sum[LEN_W-1:0];
            if (in_desc.segmented) begin
                r.status = ST_INCOMPLETE;
            end else begin
                r.complete     = 1'b1;
                r.total_length = sum[LEN_W-1:0];
                r.dest_raw     = held_reg.dest_raw;
                r.dest_size    = held_reg.dest_size;
                r.src_raw      = held_reg.src_raw;
                r.src_size     = held_reg.src_size;
                r.control      = held_reg.control;
                pending_next   = 1'b0;
            end
        end
    end

    assign res = r;

    // Control state: pending flag and limit register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= 1'b0;
            max_reg     <= '0;
        end else begin
            if (fire) begin
                pending_reg <= pending_next;
            end
            if (cfg_wr) begin
                max_reg <= cfg_data;
            end
        end
    end

    // Held header and running length, read only while pending
    always_ff @(posedge aclk) begin
        if (fire) begin
            plen_reg <= plen_next;
            held_reg <= held_next;
        end
    end

    a_complete_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && r.complete) |-> (r.status == ST_OK))
        else $error("complete result without ok status");

    a_incomplete_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && r.status == ST_INCOMPLETE) |=> pending_reg)
        else $error("incomplete result left nothing pending");

    a_discard_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && (r.status == ST_SEG_ERR || r.status == ST_OVERFLOW)) |=> !pending_reg)
        else $error("discard did not clear pending message");

    a_first_offset: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && !pending_reg) |-> (r.write_offset == '0))
        else $error("nonzero offset for a first frame");

    a_idle_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !fire |=> (pending_reg == $past(pending_reg)))
        else $error("pending state changed without a word");

endmodule

// File: rtl/hsr_out_stage.sv
// Output register stage of the HDLC segment reassembly control block.
// Holds one result word toward the receiver; depends on hsr_pkg.
module hsr_out_stage (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 r_valid,
    output logic                 r_ready,
    input  hsr_pkg::hsr_result_t r_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output hsr_pkg::hsr_result_t m_data
);
    import hsr_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    hsr_result_t data_reg;

    // Load when empty or when the receiver takes the current word
    assign r_ready = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (r_valid && r_ready) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (r_valid && r_ready) begin
            data_reg <= r_data;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

// File: rtl/hdlc_segment_reassembly_control_top.sv
// Top level of the HDLC segment reassembly control block.
// Instantiates hsr_in_stage, hsr_track and hsr_out_stage; depends on hsr_pkg.
//
// Usage:
//   s_ channel: one received frame descriptor per word (addresses, control,
//   frame kind, segmented bit, information length), valid/ready.
//   m_ channel: one result word per descriptor: status, complete flag, buffer
//   write offset and, on completion, total length and first-segment header.
//   cfg channel: writes the max total length register (zero = ceiling);
//   write it only while the block is idle. cfg_ready is always high.
// Path: an accepted descriptor is held in the input register, decided by the
//   combinational tracker and loaded into the output register for the receiver.
// Throughput: while m_ready is high, one descriptor per cycle; the tracker makes
//   one compare-and-add decision per cycle between the input and the output register.
// Reset (aresetn low, synchronous): drops any pending message, empties both
//   stages and clears the length register.
// Receiver stall: the output register holds its word; the input register
//   takes a descriptor only while it is empty, then s_ready falls until m_ready returns.
module hdlc_segment_reassembly_control_top #(
    parameter int unsigned LENGTH_LIMIT = hsr_pkg::LENGTH_LIMIT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_dest_addr_raw,
    input  logic [2:0]  s_dest_addr_size,
    input  logic [31:0] s_src_addr_raw,
    input  logic [2:0]  s_src_addr_size,
    input  logic [7:0]  s_control_byte,
    input  logic [1:0]  s_frame_kind,
    input  logic        s_segmented,
    input  logic [15:0] s_info_length,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic        m_complete,
    output logic [15:0] m_write_offset,
    output logic [15:0] m_total_length,
    output logic [31:0] m_out_dest_raw,
    output logic [2:0]  m_out_dest_size,
    output logic [31:0] m_out_src_raw,
    output logic [2:0]  m_out_src_size,
    output logic [7:0]  m_out_control
);
    import hsr_pkg::*;

    hsr_desc_t   s_desc;
    hsr_desc_t   q_desc;
    logic        q_valid;
    logic        q_ready;
    hsr_result_t r_data;
    logic        r_valid;
    logic        r_ready;
    hsr_result_t m_data;

    assign cfg_ready = 1'b1;

    // Pack the descriptor word
    assign s_desc.hdr.dest_raw  = s_dest_addr_raw;
    assign s_desc.hdr.dest_size = s_dest_addr_size;
    assign s_desc.hdr.src_raw   = s_src_addr_raw;
    assign s_desc.hdr.src_size  = s_src_addr_size;
    assign s_desc.hdr.control   = s_control_byte;
    assign s_desc.hdr.kind      = s_frame_kind;
    assign s_desc.segmented     = s_segmented;
    assign s_desc.info_length   = s_info_length;

    hsr_in_stage u_in (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_desc  (s_desc),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_desc  (q_desc)
    );

    hsr_track #(
        .LENGTH_LIMIT (LENGTH_LIMIT)
    ) u_track (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_desc   (q_desc),
        .res_valid (r_valid),
        .res_ready (r_ready),
        .res       (r_data)
    );

    hsr_out_stage u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .r_valid (r_valid),
        .r_ready (r_ready),
        .r_data  (r_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Unpack the result word
    assign m_status        = m_data.status;
    assign m_complete      = m_data.complete;
    assign m_write_offset  = m_data.write_offset;
    assign m_total_length  = m_data.total_length;
    assign m_out_dest_raw  = m_data.dest_raw;
    assign m_out_dest_size = m_data.dest_size;
    assign m_out_src_raw   = m_data.src_raw;
    assign m_out_src_size  = m_data.src_size;
    assign m_out_control   = m_data.control;

endmodule
